@@ rtl/rle_pkg.sv @@
// Shared types, constants and the RGB565 packing function for the run-length encoder.
// Depends on nothing; the top level, rle_front, rle_fifo and rle_back import it.
`default_nettype none

package rle_pkg;

  // Longest run that one pair can describe.
  localparam logic [15:0] RUN_CAP = 16'hFFFF;

  // Bit positions of the red and green fields in an RGB565 word.
  localparam int unsigned RED_POS   = 11;
  localparam int unsigned GREEN_POS = 5;

  // Default number of entries in the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // One finished run.
  typedef struct packed {
    logic [15:0] run_length;
    logic [15:0] color565;
  } run_pair_t;

  // Work for the back end caused by one pixel: an optional run closed by a
  // color change or the cap, then an optional run closed by the frame end.
  typedef struct packed {
    logic      has_split;
    run_pair_t split;
    logic      has_flush;
    run_pair_t flush;
  } rle_cmd_t;

  // Keep the top 5, 6 and 5 bits of red, green and blue.
  function automatic logic [15:0] pack565(input logic [7:0] red, input logic [7:0] green,
                                          input logic [7:0] blue);
    logic [15:0] r5;
    logic [15:0] g6;
    logic [15:0] b5;
    r5 = {11'd0, red[7:3]};
    g6 = {10'd0, green[7:2]};
    b5 = {11'd0, blue[7:3]};
    return (r5 << RED_POS) | (g6 << GREEN_POS) | b5;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rle_pixel_if.sv @@
// Valid/ready channel that carries one RGB24 pixel and its end-of-frame mark.
// Stand-alone; used by the encoder's input port.
`default_nettype none

interface rle_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_end;

  modport source (output valid, output red, output green, output blue, output frame_end,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input frame_end,
                output ready);
endinterface

`default_nettype wire

@@ rtl/rle_run_if.sv @@
// Valid/ready channel that carries one (run_length, color565) pair.
// Stand-alone; used by the encoder's output port.
`default_nettype none

interface rle_run_if;
  logic        valid;
  logic        ready;
  logic [15:0] run_length;
  logic [15:0] color565;
  logic        frame_done;

  modport source (output valid, output run_length, output color565, output frame_done,
                  input ready);
  modport sink (input valid, input run_length, input color565, input frame_done,
                output ready);
endinterface

`default_nettype wire

@@ rtl/rgb565_run_length_encoder.sv @@
// Top level of the RGB565 run-length encoder: front end, command queue and back end.
// Depends on rle_pkg, rle_pixel_if, rle_run_if, rle_front, rle_fifo and rle_back.
`default_nettype none

// Takes one RGB24 pixel per transfer on pix_i, reduces it to RGB565 and emits
// (run_length, color565, frame_done) pairs on run_o. A run closes when the color
// changes, when a pixel arrives after 65535 pixels, or on a frame_end pixel, which
// closes the run including itself with frame_done set; such a pixel can give two
// pairs. The front end takes one pixel every cycle as long as the command queue
// (QueueDepth entries) has room; the back end drains one pair per cycle while run_o
// is ready, through its output register, so a pixel that gives two pairs keeps its
// command at the queue head until both pairs are loaded. A pair passes through the
// command queue and then the output register before it appears on run_o.
module rgb565_run_length_encoder import rle_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  rle_pixel_if.sink   pix_i,
  rle_run_if.source   run_o
);

  logic     push_valid;
  logic     push_ready;
  rle_cmd_t push_data;
  logic     pop;
  logic     head_valid;
  rle_cmd_t head;

  rle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix          (pix_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  rle_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  rle_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .run          (run_o)
  );

endmodule

`default_nettype wire

@@ rtl/rle_front.sv @@
// Front end: accepts pixels, tracks the open run and queues the runs each pixel closes.
// Depends on rle_pkg and rle_pixel_if.
`default_nettype none

module rle_front import rle_pkg::*; (
  input  wire            clk_i,
  input  wire            rst_ni,
  rle_pixel_if.sink      pix,
  output logic           push_valid_o,
  output rle_cmd_t       push_data_o,
  input  wire            push_ready_i
);

  logic [15:0] color_q, color_d;
  logic [15:0] count_q, count_d;
  logic        open_q, open_d;
  logic [15:0] pix_color;
  logic        accept;
  logic        extend;
  rle_cmd_t    cmd;

  // A pixel transfers whenever the queue has room for what it may cause.
  assign pix.ready = push_ready_i;
  assign accept    = pix.valid && push_ready_i;
  assign pix_color = pack565(pix.red, pix.green, pix.blue);
  assign extend    = open_q && (pix_color == color_q) && (count_q != RUN_CAP);

  // Classify the pixel: extend the run, or close it and open a new one.
  always_comb begin
    color_d         = color_q;
    count_d         = count_q;
    open_d          = open_q;
    cmd.has_split   = 1'b0;
    cmd.split       = '{run_length: count_q, color565: color_q};
    cmd.has_flush   = 1'b0;
    cmd.flush       = '{run_length: 16'd0, color565: 16'd0};
    if (extend) begin
      count_d = count_q + 16'd1;
    end else begin
      cmd.has_split = open_q;
      color_d       = pix_color;
      count_d       = 16'd1;
      open_d        = 1'b1;
    end
    // The frame end closes the run including this pixel.
    if (pix.frame_end) begin
      cmd.has_flush = 1'b1;
      cmd.flush     = '{run_length: count_d, color565: color_d};
      color_d       = 16'd0;
      count_d       = 16'd0;
      open_d        = 1'b0;
    end
  end

  assign push_valid_o = accept && (cmd.has_split || cmd.has_flush);
  assign push_data_o  = cmd;

  // Run state advances only on an input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= 16'd0;
      count_q <= 16'd0;
      open_q  <= 1'b0;
    end else if (accept) begin
      color_q <= color_d;
      count_q <= count_d;
      open_q  <= open_d;
    end
  end

`ifndef SYNTHESIS
  // An open run always holds at least one pixel, a closed one none.
  a_open_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q == (count_q != 16'd0))
    else $error("run open flag and length disagree");
`endif

endmodule

`default_nettype wire

@@ rtl/rle_fifo.sv @@
// Short first-in first-out queue of run commands between front and back end.
// Depends on rle_pkg.
`default_nettype none

module rle_fifo import rle_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       push_i,
  input  rle_cmd_t  push_data_i,
  output logic      push_ready_o,
  input  wire       pop_i,
  output logic      head_valid_o,
  output rle_cmd_t  head_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  rle_cmd_t         entry_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!do_push && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // The front end never offers a command to a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> push_ready_o)
    else $error("push into full queue");

  // The fill count stays within the depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count out of range");
`endif

endmodule

`default_nettype wire

@@ rtl/rle_back.sv @@
// Back end: unpacks queued commands into one or two run pairs and holds each in an
// output register until its transfer. Depends on rle_pkg and rle_run_if.
`default_nettype none

module rle_back import rle_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        head_valid_i,
  input  rle_cmd_t   head_i,
  output logic       pop_o,
  rle_run_if.source  run
);

  logic      out_valid_q, out_valid_d;
  run_pair_t pair_q, pair_d;
  logic      done_q, done_d;
  logic      phase_q, phase_d;
  logic      load;
  logic      sel_flush;

  // The output register takes a new pair when it is empty or being drained.
  assign load      = !out_valid_q || run.ready;
  assign sel_flush = phase_q || !head_i.has_split;

  // Choose the next pair of the head command and decide when it is used up.
  always_comb begin
    out_valid_d = out_valid_q;
    pair_d      = pair_q;
    done_d      = done_q;
    phase_d     = phase_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        if (sel_flush) begin
          pair_d  = head_i.flush;
          done_d  = 1'b1;
          phase_d = 1'b0;
          pop_o   = 1'b1;
        end else begin
          pair_d  = head_i.split;
          done_d  = 1'b0;
          phase_d = head_i.has_flush;
          pop_o   = !head_i.has_flush;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
    done_q <= done_d;
  end

  assign run.valid      = out_valid_q;
  assign run.run_length = pair_q.run_length;
  assign run.color565   = pair_q.color565;
  assign run.frame_done = done_q;

`ifndef SYNTHESIS
  // While the second pair is pending, its command is still at the queue head.
  a_phase_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (head_valid_i && head_i.has_flush))
    else $error("flush pair pending without its command");
`endif

endmodule

`default_nettype wire
